// ===== rtl/uarx_pkg.sv =====
// Shared types and constants for the oversampled UART receiver.
// No dependencies; imported by every module of the receiver.
`default_nettype none

package uarx_pkg;

    // Start hunt: last four samples, oldest in the MSB
    localparam logic [3:0] HUNT_MASK     = 4'hF;
    localparam logic [3:0] START_PATTERN = 4'hC;

    // Frame layout
    localparam int         DATA_BITS     = 8;
    localparam logic [7:0] DATA_MSB      = 8'h80;
    localparam logic [3:0] BIT_FIRST     = 4'd1;
    localparam logic [3:0] BIT_LAST_DATA = 4'd8;
    localparam logic [3:0] BIT_NINTH     = 4'd9;

    // parity_mode codes
    localparam logic [1:0] PAR_NONE = 2'd0;
    localparam logic [1:0] PAR_EVEN = 2'd1;
    localparam logic [1:0] PAR_ODD  = 2'd2;

    // parity_status codes
    localparam logic [1:0] PSTAT_UNCHECKED = 2'd0;
    localparam logic [1:0] PSTAT_OK        = 2'd1;
    localparam logic [1:0] PSTAT_ERROR     = 2'd2;

    // Register indexes on the config port
    localparam logic REG_PARITY_MODE = 1'b0;
    localparam logic REG_RX_ENABLE   = 1'b1;
    localparam int   PADDR_W         = 3;

    typedef struct packed {
        logic [1:0] parity_mode;
        logic       rx_enable;
    } cfg_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] rx_byte;
        logic [1:0]           parity_status;
        logic                 stop_ok;
    } rx_result_t;

endpackage

`default_nettype wire

// ===== rtl/uart_rx_oversampled_parity_core.sv =====
// A result beat appears on out_valid in the cycle after the stop-sample beat is accepted.
// Accepts one line sample per cycle; in_ready drops only while a result waits unclaimed
// in the single output register.
// After the start is detected a frame spans 9 or 10 bit times of SAMPLES_PER_BIT samples each.
// Reset (rst_n low, asynchronous): receiver idle, hunt cleared, registers zero except the output payload, output empty.
// Top level of the oversampled UART receiver; uses uarx_pkg, uarx_apb, uarx_frame, uarx_out.
`default_nettype none

module uart_rx_oversampled_parity_core #(
    parameter int SAMPLES_PER_BIT = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // config port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [uarx_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    // sample channel
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         line_level,
    // result channel
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [uarx_pkg::DATA_BITS-1:0]    rx_byte,
    output logic [1:0]                        parity_status,
    output logic                              stop_ok
);
    import uarx_pkg::*;

    cfg_t       cfg;
    rx_result_t res;
    rx_result_t res_out;
    logic       res_valid;
    logic       space;
    logic       step;

    assign in_ready = space;
    assign step     = in_valid & in_ready;

    uarx_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    uarx_frame #(
        .SAMPLES_PER_BIT (SAMPLES_PER_BIT)
    ) u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .level     (line_level),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    uarx_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res_in    (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .space     (space),
        .res_out   (res_out)
    );

    assign rx_byte       = res_out.rx_byte;
    assign parity_status = res_out.parity_status;
    assign stop_ok       = res_out.stop_ok;

endmodule

`default_nettype wire

// ===== rtl/uarx_apb.sv =====
// APB-style configuration registers: parity_mode and rx_enable.
// Depends on uarx_pkg.
`default_nettype none

module uarx_apb (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [uarx_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output uarx_pkg::cfg_t                    cfg
);
    import uarx_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    // Write decode, value masked to register width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_PARITY_MODE: cfg_next.parity_mode = pwdata[1:0];
                REG_RX_ENABLE:   cfg_next.rx_enable   = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_sel)
            REG_PARITY_MODE: prdata = {30'd0, cfg_reg.parity_mode};
            REG_RX_ENABLE:   prdata = {31'd0, cfg_reg.rx_enable};
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/uarx_frame.sv =====
// Per-tick receiver state: start hunt, bit timing, data/parity capture.
// Depends on uarx_pkg.
`default_nettype none

module uarx_frame #(
    parameter int SAMPLES_PER_BIT = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic                 level,
    input  wire uarx_pkg::cfg_t       cfg,
    output logic                      res_valid,
    output uarx_pkg::rx_result_t      res
);
    import uarx_pkg::*;

    localparam int              TICK_W    = $clog2(SAMPLES_PER_BIT);
    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(SAMPLES_PER_BIT - 1);

    logic [3:0]           hunt_shift_reg,    hunt_shift_next;
    logic                 receiving_reg,     receiving_next;
    logic [TICK_W-1:0]    tick_count_reg,    tick_count_next;
    logic [3:0]           bit_index_reg,     bit_index_next;
    logic [DATA_BITS-1:0] data_shift_reg,    data_shift_next;
    logic                 ones_parity_reg,   ones_parity_next;
    logic [1:0]           parity_result_reg, parity_result_next;

    logic [3:0] hunt_shifted;
    logic [3:0] bit_inc;
    logic       par_odd;

    assign hunt_shifted = {hunt_shift_reg[2:0], level} & HUNT_MASK;
    assign bit_inc      = bit_index_reg + 4'd1;
    assign par_odd      = ones_parity_reg ^ level;

    // Next-state for one sample beat
    always_comb
    begin
        hunt_shift_next    = hunt_shift_reg;
        receiving_next     = receiving_reg;
        tick_count_next    = tick_count_reg;
        bit_index_next     = bit_index_reg;
        data_shift_next    = data_shift_reg;
        ones_parity_next   = ones_parity_reg;
        parity_result_next = parity_result_reg;
        res_valid          = 1'b0;

        if (step && cfg.rx_enable)
        begin
            if (!receiving_reg)
            begin
                // hunting for high,high,low,low
                if (hunt_shifted == START_PATTERN)
                begin
                    receiving_next     = 1'b1;
                    hunt_shift_next    = '0;
                    tick_count_next    = '0;
                    bit_index_next     = '0;
                    data_shift_next    = '0;
                    ones_parity_next   = 1'b0;
                    parity_result_next = PSTAT_UNCHECKED;
                end
                else
                begin
                    hunt_shift_next = hunt_shifted;
                end
            end
            else if (tick_count_reg != TICK_LAST)
            begin
                tick_count_next = tick_count_reg + TICK_W'(1);
            end
            else
            begin
                // bit sample point
                tick_count_next = '0;
                bit_index_next  = bit_inc;
                if (bit_inc inside {[BIT_FIRST:BIT_LAST_DATA]})
                begin
                    data_shift_next  = (data_shift_reg >> 1) | (level ? DATA_MSB : '0);
                    ones_parity_next = par_odd;
                end
                else if (bit_inc == BIT_NINTH)
                begin
                    case (cfg.parity_mode)
                        PAR_NONE: res_valid = 1'b1;
                        PAR_EVEN: parity_result_next = !par_odd ? PSTAT_OK : PSTAT_ERROR;
                        PAR_ODD:  parity_result_next = par_odd ? PSTAT_OK : PSTAT_ERROR;
                        default:  parity_result_next = parity_result_reg;
                    endcase
                end
                else
                begin
                    res_valid = 1'b1;
                end
                if (res_valid)
                begin
                    receiving_next = 1'b0;
                end
            end
        end
    end

    // Result fields for a stop sample
    assign res.rx_byte       = data_shift_reg;
    assign res.parity_status = parity_result_reg;
    assign res.stop_ok       = level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunt_shift_reg    <= '0;
            receiving_reg     <= 1'b0;
            tick_count_reg    <= '0;
            bit_index_reg     <= '0;
            data_shift_reg    <= '0;
            ones_parity_reg   <= 1'b0;
            parity_result_reg <= PSTAT_UNCHECKED;
        end
        else
        begin
            hunt_shift_reg    <= hunt_shift_next;
            receiving_reg     <= receiving_next;
            tick_count_reg    <= tick_count_next;
            bit_index_reg     <= bit_index_next;
            data_shift_reg    <= data_shift_next;
            ones_parity_reg   <= ones_parity_next;
            parity_result_reg <= parity_result_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/uarx_out.sv =====
// Output result register with valid/ready handshake.
// Depends on uarx_pkg.
`default_nettype none

module uarx_out (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire uarx_pkg::rx_result_t res_in,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic                      space,
    output uarx_pkg::rx_result_t      res_out
);
    import uarx_pkg::*;

    logic       out_valid_reg, out_valid_next;
    rx_result_t res_reg;

    // Room for a new beat when empty or draining this cycle
    assign space = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_out   = res_reg;

endmodule

`default_nettype wire

// ===== rtl/uarx_checker.sv =====
// Port-level checks for the UART receiver, attached by bind.
// Depends on uart_rx_oversampled_parity_core.
`default_nettype none

module uarx_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] rx_byte,
    input wire logic [1:0] parity_status,
    input wire logic       stop_ok
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rx_byte)
            && $stable(parity_status) && $stable(stop_ok))
        else $error("result beat changed while stalled");

    // Full output register blocks new samples
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("sample accepted with result stalled");

    // A result only follows an accepted sample
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without an accepted sample");

    // parity_status never shows the unused code
    a_pstat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> parity_status != 2'd3)
        else $error("illegal parity status");

endmodule

bind uart_rx_oversampled_parity_core uarx_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .rx_byte       (rx_byte),
    .parity_status (parity_status),
    .stop_ok       (stop_ok)
);

`default_nettype wire
